// ===== rtl/qtsh_pkg.sv =====
// ----------------------------------------------------------------------------
// qtsh_pkg
// Shared types, codes and helpers of the nonclassical force unit.
// ----------------------------------------------------------------------------
package qtsh_pkg;

  // request kinds as they travel from the front to the back
  typedef enum logic [2:0] {
    CMD_LD_H    = 3'd0,
    CMD_LD_C    = 3'd1,
    CMD_LD_G    = 3'd2,
    CMD_LD_A    = 3'd3,
    CMD_COMPUTE = 3'd4
  } cmd_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_STATES = 2'd1,
    CFG_DOFS   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    cmd_e               kind;
    logic [3:0]         dof;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] vr;
    logic signed [31:0] vi;
  } cmd_t;

  typedef struct packed {
    logic       mode;
    logic [3:0] states;
    logic [4:0] dofs;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
    logic signed [32:0] r;
    r = {v[31], v};
    return r;
  endfunction

endpackage

// ===== rtl/qtsh_force_adiabatic.sv =====
// ----------------------------------------------------------------------------
// qtsh_force_adiabatic
// Nonclassical force unit, adiabatic basis, signed fixed point.
// ----------------------------------------------------------------------------
// Request beats enter on the s_axis channel: tuser holds the request kind,
// tdata the dof, row, column and complex value. Loads of the Hamiltonian,
// coupling, gradient and amplitude stores take one beat a cycle while the
// two-entry queue has room and are written one a cycle by the back end.
// A compute request emits one force beat per dof on m_axis, tlast on the
// final one, tuser set when the amplitude norm is zero (force then zero).
// A compute walks the stores with a single shared multiplier, one real
// product a cycle plus read and step overhead: first the norm over the
// amplitudes, then per dof the off-diagonal pairs (with coupling and
// Hamiltonian products added when mode_select is 0) and two 64-step
// restoring divisions (skipped at zero norm).
// Loads queued behind a compute wait for it to finish.
// Configuration writes on cfg_* are always taken and only meant while idle.
// Reset sets mode 0, 8 states, 16 dofs; store contents are undefined until
// loaded. A stalled m_axis holds the pending force and the next one waits.
// ----------------------------------------------------------------------------
module qtsh_force_adiabatic #(
  parameter int MAX_STATES = 8,
  parameter int MAX_DOFS   = 16,
  parameter int FRAC_BITS  = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // dof_index, row_index, col_index, value_re, value_im
  input  logic [2:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // force_dof, force_re, force_im
  output logic [0:0]  m_axis_tuser,  // norm_zero
  output logic        m_axis_tlast,  // last_force
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  qtsh_pkg::cfg_t     cfg_q;
  qtsh_pkg::cmd_t     cmd;
  logic               cmd_valid, cmd_pop;
  logic [3:0]         o_dof;
  logic signed [31:0] o_re, o_im;
  logic               o_nz;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= 1'b0;
      cfg_q.states <= 4'd8;
      cfg_q.dofs   <= 5'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        qtsh_pkg::CFG_MODE:   cfg_q.mode   <= cfg_data_i[0];
        qtsh_pkg::CFG_STATES: cfg_q.states <= cfg_data_i[3:0];
        qtsh_pkg::CFG_DOFS:   cfg_q.dofs   <= cfg_data_i;
        default:              cfg_q        <= cfg_q;
      endcase
    end
  end

  qtsh_front #(
    .MAX_STATES(MAX_STATES),
    .MAX_DOFS  (MAX_DOFS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .req_type_i (s_axis_tuser),
    .dof_i      (s_axis_tdata[3:0]),
    .row_i      (s_axis_tdata[6:4]),
    .col_i      (s_axis_tdata[9:7]),
    .vr_i       (s_axis_tdata[41:10]),
    .vi_i       (s_axis_tdata[73:42]),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  qtsh_back #(
    .MAX_STATES(MAX_STATES),
    .MAX_DOFS  (MAX_DOFS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_dof_o  (o_dof),
    .out_re_o   (o_re),
    .out_im_o   (o_im),
    .out_nz_o   (o_nz),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, o_im, o_re, o_dof};
  assign m_axis_tuser = o_nz;

endmodule

// ===== rtl/qtsh_front.sv =====
// ----------------------------------------------------------------------------
// qtsh_front
// Takes request beats, drops unknown kinds and out-of-range loads, and keeps
// the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module qtsh_front #(
  parameter int MAX_STATES = 8,
  parameter int MAX_DOFS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic [3:0]         dof_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic signed [31:0] vr_i,
  input  logic signed [31:0] vi_i,
  output logic               cmd_valid_o,
  output qtsh_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);

  logic           keep;
  logic           row_ok, col_ok, dof_ok;
  logic           push;
  logic [1:0]     cnt_q;
  logic           wr_q, rd_q;
  qtsh_pkg::cmd_t fifo_q [2];
  qtsh_pkg::cmd_t cmd_c;

  assign row_ok = int'(row_i) < MAX_STATES;
  assign col_ok = int'(col_i) < MAX_STATES;
  assign dof_ok = int'(dof_i) < MAX_DOFS;

  always_comb begin
    keep = 1'b0;
    unique case (req_type_i) inside
      qtsh_pkg::CMD_LD_H:                     keep = row_ok && col_ok;
      qtsh_pkg::CMD_LD_C, qtsh_pkg::CMD_LD_G: keep = row_ok && col_ok && dof_ok;
      qtsh_pkg::CMD_LD_A:                     keep = row_ok;
      qtsh_pkg::CMD_COMPUTE:                  keep = 1'b1;
      default:                                keep = 1'b0;
    endcase
    cmd_c.kind = qtsh_pkg::cmd_e'(req_type_i);
    cmd_c.dof  = dof_i;
    cmd_c.row  = row_i;
    cmd_c.col  = col_i;
    cmd_c.vr   = vr_i;
    cmd_c.vi   = vi_i;
  end

  assign in_ready_o  = cnt_q != 2'd2;
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (cmd_pop_i) rd_q <= !rd_q;
      if (push && !cmd_pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push && cmd_pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cmd_c;
  end

endmodule

// ===== rtl/qtsh_div.sv =====
// ----------------------------------------------------------------------------
// qtsh_div
// Radix-2 restoring divider: signed dividend over a positive divisor,
// quotient truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module qtsh_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [63:0]        den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [64:0] rem_q;
  logic [63:0] quo_q;
  logic [63:0] den_q;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_q[63:0], quo_q[63]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= num_i < 0;
        quo_q  <= (num_i < 0) ? 64'(-num_i) : 64'(num_i);
        rem_q  <= '0;
        den_q  <= den_i;
        cnt_q  <= '0;
      end else if (busy_q) begin
        rem_q <= fits ? trial - {1'b0, den_q} : trial;
        quo_q <= {quo_q[62:0], fits};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;

  always_comb begin
    if (neg_q) begin
      if (quo_q > 64'd2147483648) quot_o = 32'sh80000000;
      else quot_o = -quo_q[31:0];
    end else begin
      if (quo_q > 64'd2147483647) quot_o = 32'sh7FFFFFFF;
      else quot_o = quo_q[31:0];
    end
  end

endmodule

// ===== rtl/qtsh_back.sv =====
// ----------------------------------------------------------------------------
// qtsh_back
// Executes queued requests: writes the stores on loads, and on a compute
// walks the stores with one shared multiplier to produce one force per dof.
// ----------------------------------------------------------------------------
module qtsh_back #(
  parameter int MAX_STATES = 8,
  parameter int MAX_DOFS   = 16,
  parameter int FRAC_BITS  = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qtsh_pkg::cfg_t     cfg_i,
  input  logic               cmd_valid_i,
  input  qtsh_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         out_dof_o,
  output logic signed [31:0] out_re_o,
  output logic signed [31:0] out_im_o,
  output logic               out_nz_o,
  output logic               out_last_o
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int DW = (MAX_DOFS > 1) ? $clog2(MAX_DOFS) : 1;
  localparam int HW = 2 * SW;
  localparam int CW = DW + 2 * SW;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_LATCH = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_STEP  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_G    = 3'd1,
    OP_P1   = 3'd2,
    OP_P2   = 3'd3,
    OP_V    = 3'd4,
    OP_S    = 3'd5
  } op_e;

  logic [63:0] ham_mem [1 << HW];
  logic [63:0] cpl_mem [1 << CW];
  logic [63:0] grd_mem [1 << CW];
  logic [63:0] amp_mem [1 << SW];
  logic [63:0] ham_rd_q, cpl_rd_q, grd_rd_q, amp_rd_q;
  logic [HW-1:0] ham_ra, ham_wa;
  logic [CW-1:0] cpl_ra, grd_ra, cw_wa;
  logic [SW-1:0] amp_ra;

  state_e  state_q;
  op_e     op_q;
  logic    mode_q;
  logic [SW-1:0] i_q, j_q, k_q, ns_m1_q, ns_m1_c;
  logic [DW-1:0] n_q, nd_m1_q, nd_m1_c;
  logic [2:0] ph_q;
  logic signed [32:0] xr_q, xi_q, yr_q, yi_q, ma, mb;
  logic signed [65:0] prod_q, rsum, rsh;
  logic signed [63:0] rnd, d_re, d_im;
  logic signed [63:0] norm_q, p_re_q, p_im_q, v_re_q, v_im_q, s_re_q, s_im_q;
  logic signed [31:0] m_re_q, m_im_q, fr_q, fi_q;
  logic [SW:0] j_p1, j_p2, jn;
  logic        j_done;
  logic        div_run_q, div_im_q, div_start, div_done;
  logic signed [63:0] s_sel, div_num;
  logic signed [31:0] div_quot;
  logic        out_valid_q, out_nz_q, out_last_q;
  logic [3:0]  out_dof_q;
  logic signed [31:0] out_re_q, out_im_q;
  logic        pop, out_free;

  // count clamps: zero taken as one, beyond the store size taken as its size
  always_comb begin
    if (cfg_i.states == 4'd0) ns_m1_c = '0;
    else if (int'(cfg_i.states) > MAX_STATES) ns_m1_c = SW'(MAX_STATES - 1);
    else ns_m1_c = SW'(cfg_i.states - 4'd1);
    if (cfg_i.dofs == 5'd0) nd_m1_c = '0;
    else if (int'(cfg_i.dofs) > MAX_DOFS) nd_m1_c = DW'(MAX_DOFS - 1);
    else nd_m1_c = DW'(cfg_i.dofs - 5'd1);
  end

  assign pop       = (state_q == ST_IDLE) && cmd_valid_i;
  assign cmd_pop_o = pop;

  // store writes
  assign ham_wa = {SW'(cmd_i.row), SW'(cmd_i.col)};
  assign cw_wa  = {DW'(cmd_i.dof), SW'(cmd_i.row), SW'(cmd_i.col)};

  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.kind == qtsh_pkg::CMD_LD_H) ham_mem[ham_wa] <= {cmd_i.vi, cmd_i.vr};
    if (pop && cmd_i.kind == qtsh_pkg::CMD_LD_C) cpl_mem[cw_wa] <= {cmd_i.vi, cmd_i.vr};
    if (pop && cmd_i.kind == qtsh_pkg::CMD_LD_G) grd_mem[cw_wa] <= {cmd_i.vi, cmd_i.vr};
    if (pop && cmd_i.kind == qtsh_pkg::CMD_LD_A) amp_mem[SW'(cmd_i.row)] <= {cmd_i.vi, cmd_i.vr};
    ham_rd_q <= ham_mem[ham_ra];
    cpl_rd_q <= cpl_mem[cpl_ra];
    grd_rd_q <= grd_mem[grd_ra];
    amp_rd_q <= amp_mem[amp_ra];
  end

  // P1 reads C[k][i] and H[k][j], P2 reads H[k][i] and C[k][j]
  assign ham_ra = {k_q, (op_q == OP_P1) ? j_q : i_q};
  assign cpl_ra = {n_q, k_q, (op_q == OP_P1) ? i_q : j_q};
  assign grd_ra = {n_q, i_q, j_q};
  assign amp_ra = (op_q == OP_V) ? j_q : i_q;

  // one real product a phase: xr*yr, xi*yi, xr*yi, xi*yr
  assign ma   = (ph_q == 3'd0 || ph_q == 3'd2) ? xr_q : xi_q;
  assign mb   = (ph_q == 3'd0 || ph_q == 3'd3) ? yr_q : yi_q;
  assign rsum = prod_q + (66'sd1 <<< (FRAC_BITS - 1));
  assign rsh  = rsum >>> FRAC_BITS;
  assign rnd  = rsh[63:0];

  always_comb begin
    d_re = '0;
    d_im = '0;
    case (ph_q)
      3'd1:    d_re = rnd;
      3'd2:    d_re = -rnd;
      3'd3:    d_im = rnd;
      3'd4:    d_im = rnd;
      default: d_re = '0;
    endcase
  end

  // next column, stepping over the diagonal
  assign j_p1   = {1'b0, j_q} + 1'b1;
  assign j_p2   = {1'b0, j_q} + 2'd2;
  assign jn     = (j_p1 == {1'b0, i_q}) ? j_p2 : j_p1;
  assign j_done = jn > {1'b0, ns_m1_q};

  assign out_free  = !out_valid_q || out_ready_i;
  assign s_sel     = div_im_q ? s_im_q : s_re_q;
  assign div_num   = (-s_sel) <<< FRAC_BITS;
  assign div_start = (state_q == ST_DIV) && !div_run_q;

  qtsh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (64'(norm_q)),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q <= OP_NORM;
      mode_q <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0; n_q <= '0;
      ns_m1_q <= '0; nd_m1_q <= '0; ph_q <= '0;
      xr_q <= '0; xi_q <= '0; yr_q <= '0; yi_q <= '0; prod_q <= '0;
      norm_q <= '0; p_re_q <= '0; p_im_q <= '0; v_re_q <= '0; v_im_q <= '0;
      s_re_q <= '0; s_im_q <= '0; m_re_q <= '0; m_im_q <= '0;
      fr_q <= '0; fi_q <= '0; div_run_q <= 1'b0; div_im_q <= 1'b0;
      out_valid_q <= 1'b0; out_nz_q <= 1'b0; out_last_q <= 1'b0;
      out_dof_q <= '0; out_re_q <= '0; out_im_q <= '0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i && cmd_i.kind == qtsh_pkg::CMD_COMPUTE) begin
            mode_q  <= cfg_i.mode;
            ns_m1_q <= ns_m1_c;
            nd_m1_q <= nd_m1_c;
            norm_q  <= '0;
            i_q     <= '0;
            op_q    <= OP_NORM;
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: state_q <= ST_LATCH;
        ST_LATCH: begin
          state_q <= ST_MUL;
          ph_q    <= '0;
          case (op_q)
            OP_NORM: begin
              xr_q <= qtsh_pkg::ext33(amp_rd_q[31:0]);
              xi_q <= qtsh_pkg::ext33(amp_rd_q[63:32]);
              yr_q <= qtsh_pkg::ext33(amp_rd_q[31:0]);
              yi_q <= -qtsh_pkg::ext33(amp_rd_q[63:32]);
            end
            OP_G: begin
              m_re_q <= grd_rd_q[31:0];
              m_im_q <= grd_rd_q[63:32];
              state_q <= ST_FETCH;
              if (!mode_q) begin
                p_re_q <= '0;
                p_im_q <= '0;
                k_q    <= '0;
                op_q   <= OP_P1;
              end else begin
                op_q <= OP_V;
              end
            end
            OP_P1: begin
              xr_q <= qtsh_pkg::ext33(cpl_rd_q[31:0]);
              xi_q <= -qtsh_pkg::ext33(cpl_rd_q[63:32]);
              yr_q <= qtsh_pkg::ext33(ham_rd_q[31:0]);
              yi_q <= qtsh_pkg::ext33(ham_rd_q[63:32]);
            end
            OP_P2: begin
              xr_q <= qtsh_pkg::ext33(ham_rd_q[31:0]);
              xi_q <= -qtsh_pkg::ext33(ham_rd_q[63:32]);
              yr_q <= qtsh_pkg::ext33(cpl_rd_q[31:0]);
              yi_q <= qtsh_pkg::ext33(cpl_rd_q[63:32]);
            end
            OP_V: begin
              xr_q <= qtsh_pkg::ext33(m_re_q);
              xi_q <= qtsh_pkg::ext33(m_im_q);
              yr_q <= qtsh_pkg::ext33(amp_rd_q[31:0]);
              yi_q <= qtsh_pkg::ext33(amp_rd_q[63:32]);
            end
            OP_S: begin
              xr_q <= qtsh_pkg::ext33(amp_rd_q[31:0]);
              xi_q <= -qtsh_pkg::ext33(amp_rd_q[63:32]);
              yr_q <= qtsh_pkg::ext33(qtsh_pkg::sat32(v_re_q));
              yi_q <= qtsh_pkg::ext33(qtsh_pkg::sat32(v_im_q));
            end
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_MUL: begin
          ph_q <= ph_q + 3'd1;
          if (ph_q != 3'd4) prod_q <= ma * mb;
          else state_q <= ST_STEP;
          if (ph_q != 3'd0) begin
            case (op_q) inside
              OP_NORM: norm_q <= norm_q + d_re;
              OP_P1, OP_P2: begin
                p_re_q <= p_re_q + d_re;
                p_im_q <= p_im_q + d_im;
              end
              OP_V: begin
                v_re_q <= v_re_q + d_re;
                v_im_q <= v_im_q + d_im;
              end
              OP_S: begin
                s_re_q <= s_re_q + d_re;
                s_im_q <= s_im_q + d_im;
              end
              default: norm_q <= norm_q;
            endcase
          end
        end
        ST_STEP: begin
          state_q <= ST_FETCH;
          case (op_q)
            OP_NORM: begin
              if (i_q == ns_m1_q) begin
                n_q <= '0;
                s_re_q <= '0; s_im_q <= '0; v_re_q <= '0; v_im_q <= '0;
                i_q <= '0;
                j_q <= SW'(1);
                op_q <= (ns_m1_q == '0) ? OP_S : OP_G;
              end else begin
                i_q <= i_q + 1'b1;
              end
            end
            OP_P1: op_q <= OP_P2;
            OP_P2: begin
              if (k_q == ns_m1_q) begin
                m_re_q <= qtsh_pkg::sat32(64'(m_re_q) - p_re_q);
                m_im_q <= qtsh_pkg::sat32(64'(m_im_q) - p_im_q);
                op_q <= OP_V;
              end else begin
                k_q <= k_q + 1'b1;
                op_q <= OP_P1;
              end
            end
            OP_V: begin
              if (!j_done) begin
                j_q  <= jn[SW-1:0];
                op_q <= OP_G;
              end else begin
                op_q <= OP_S;
              end
            end
            OP_S: begin
              if (i_q == ns_m1_q) begin
                s_re_q <= 64'(qtsh_pkg::sat32(s_re_q));
                s_im_q <= 64'(qtsh_pkg::sat32(s_im_q));
                if (norm_q == '0) begin
                  fr_q <= '0;
                  fi_q <= '0;
                  state_q <= ST_EMIT;
                end else begin
                  div_im_q  <= 1'b0;
                  div_run_q <= 1'b0;
                  state_q   <= ST_DIV;
                end
              end else begin
                i_q <= i_q + 1'b1;
                j_q <= '0;
                v_re_q <= '0;
                v_im_q <= '0;
                op_q <= OP_G;
              end
            end
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_DIV: begin
          if (!div_run_q) begin
            div_run_q <= 1'b1;
          end else if (div_done) begin
            if (!div_im_q) begin
              fr_q      <= div_quot;
              div_im_q  <= 1'b1;
              div_run_q <= 1'b0;
            end else begin
              fi_q    <= div_quot;
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_dof_q   <= 4'(n_q);
            out_re_q    <= fr_q;
            out_im_q    <= fi_q;
            out_nz_q    <= norm_q == '0;
            out_last_q  <= n_q == nd_m1_q;
            if (n_q == nd_m1_q) begin
              state_q <= ST_IDLE;
            end else begin
              n_q <= n_q + 1'b1;
              s_re_q <= '0; s_im_q <= '0; v_re_q <= '0; v_im_q <= '0;
              i_q <= '0;
              j_q <= SW'(1);
              op_q <= (ns_m1_q == '0) ? OP_S : OP_G;
              state_q <= ST_FETCH;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dof_o   = out_dof_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign out_nz_o    = out_nz_q;
  assign out_last_o  = out_last_q;

  a_nz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_nz_q |-> out_re_q == '0 && out_im_q == '0)
    else $error("zero-norm force is not zero");

  a_div_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> norm_q != '0)
    else $error("division entered with zero norm");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> i_q <= ns_m1_q)
    else $error("row counter beyond state count");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && out_free && n_q == nd_m1_q |=> state_q == ST_IDLE)
    else $error("run did not end after last force");

endmodule

// ===== tb/qtsh_force_adiabatic_test.sv =====
// ----------------------------------------------------------------------------
// qtsh_force_adiabatic_test
// Self-checking bench of the nonclassical force unit.
// ----------------------------------------------------------------------------
// Every store entry that a compute can read is filled first: the Hamiltonian,
// the amplitudes, dof 0 in full and dof 1 for the first four states. Directed
// requests then cover the value extremes, clamped counts, single state, zero
// norm and both modes. Random phases follow, each with its own register
// setting kept inside the filled part. A scoreboard class keeps a bit-true
// copy of the stores and the force math and checks each force beat in order.
// ----------------------------------------------------------------------------
module qtsh_force_adiabatic_test;

  localparam int NS_MAX   = 8;
  localparam int ND_MAX   = 16;
  localparam int FB       = 24;
  localparam int LIMIT    = 4000000;
  localparam int N_RANDOM = 80;

  typedef struct {
    logic [3:0] dof;
    int         f_re;
    int         f_im;
    logic       nz;
    logic       last;
  } force_t;

  class force_board;
    int     h_re[NS_MAX*NS_MAX], h_im[NS_MAX*NS_MAX];
    int     c_re[ND_MAX*NS_MAX*NS_MAX], c_im[ND_MAX*NS_MAX*NS_MAX];
    int     g_re[ND_MAX*NS_MAX*NS_MAX], g_im[ND_MAX*NS_MAX*NS_MAX];
    int     a_re[NS_MAX], a_im[NS_MAX];
    bit     mode = 0;
    int     states = 8;
    int     dofs = 16;
    force_t forces_due[$];
    int     errors = 0;

    function longint qmul(longint x, longint y);
      longint p;
      p = x * y + (64'sd1 <<< (FB - 1));
      return p >>> FB;
    endfunction

    function longint clip(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function void set_reg(qtsh_pkg::cfg_idx_e idx, logic [4:0] v);
      case (idx)
        qtsh_pkg::CFG_MODE:   mode = v[0];
        qtsh_pkg::CFG_STATES: states = v[3:0];
        default:              dofs = v;
      endcase
    endfunction

    function int eff_states();
      return (states < 1) ? 1 : (states > NS_MAX) ? NS_MAX : states;
    endfunction

    function int eff_dofs();
      return (dofs < 1) ? 1 : (dofs > ND_MAX) ? ND_MAX : dofs;
    endfunction

    function void note_request(logic [2:0] kind, logic [3:0] dof, logic [2:0] row,
                               logic [2:0] col, int vr, int vi);
      int e;
      e = row * NS_MAX + col;
      case (kind)
        qtsh_pkg::CMD_LD_H: begin h_re[e] = vr; h_im[e] = vi; end
        qtsh_pkg::CMD_LD_C: begin c_re[dof*64 + e] = vr; c_im[dof*64 + e] = vi; end
        qtsh_pkg::CMD_LD_G: begin g_re[dof*64 + e] = vr; g_im[dof*64 + e] = vi; end
        qtsh_pkg::CMD_LD_A: begin a_re[row] = vr; a_im[row] = vi; end
        qtsh_pkg::CMD_COMPUTE: predict_forces();
        default: ;
      endcase
    endfunction

    // conj(a_i) * sum_j M_ij a_j over off-diagonal pairs, one beat per dof
    function void predict_forces();
      int     ns, nd, b, ki, kj, e;
      longint norm, sr, si, vr, vi, mr, mi, pr, pi, x, y;
      force_t f;
      ns = eff_states();
      nd = eff_dofs();
      norm = 0;
      for (int i = 0; i < ns; i++) norm += qmul(a_re[i], a_re[i]) + qmul(a_im[i], a_im[i]);
      for (int n = 0; n < nd; n++) begin
        b = n * 64;
        sr = 0; si = 0;
        for (int i = 0; i < ns; i++) begin
          vr = 0; vi = 0;
          for (int j = 0; j < ns; j++) begin
            if (i != j) begin
              e = i * NS_MAX + j;
              mr = g_re[b + e];
              mi = g_im[b + e];
              if (!mode) begin
                pr = 0; pi = 0;
                for (int k = 0; k < ns; k++) begin
                  ki = k * NS_MAX + i;
                  kj = k * NS_MAX + j;
                  x = c_re[b + ki]; y = -longint'(c_im[b + ki]);
                  pr += qmul(x, h_re[kj]) - qmul(y, h_im[kj]);
                  pi += qmul(x, h_im[kj]) + qmul(y, h_re[kj]);
                  x = h_re[ki]; y = -longint'(h_im[ki]);
                  pr += qmul(x, c_re[b + kj]) - qmul(y, c_im[b + kj]);
                  pi += qmul(x, c_im[b + kj]) + qmul(y, c_re[b + kj]);
                end
                mr -= pr;
                mi -= pi;
              end
              mr = clip(mr);
              mi = clip(mi);
              vr += qmul(mr, a_re[j]) - qmul(mi, a_im[j]);
              vi += qmul(mr, a_im[j]) + qmul(mi, a_re[j]);
            end
          end
          vr = clip(vr);
          vi = clip(vi);
          x = a_re[i]; y = -longint'(a_im[i]);
          sr += qmul(x, vr) - qmul(y, vi);
          si += qmul(x, vi) + qmul(y, vr);
        end
        sr = clip(sr);
        si = clip(si);
        f.dof  = 4'(n);
        f.nz   = (norm == 0);
        f.last = (n == nd - 1);
        f.f_re = 0;
        f.f_im = 0;
        if (norm != 0) begin
          f.f_re = int'(clip((-sr * (64'sd1 <<< FB)) / norm));
          f.f_im = int'(clip((-si * (64'sd1 <<< FB)) / norm));
        end
        forces_due.push_back(f);
      end
    endfunction

    function void check_force(force_t got);
      force_t w;
      if (forces_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected force beat dof %0d", got.dof);
        return;
      end
      w = forces_due.pop_front();
      if (got.dof !== w.dof || got.f_re !== w.f_re || got.f_im !== w.f_im ||
          got.nz !== w.nz || got.last !== w.last) begin
        errors++;
        if (errors <= 10)
          $display({"force mismatch: exp dof %0d re %0d im %0d nz %0b last %0b,",
                    " got dof %0d re %0d im %0d nz %0b last %0b"},
                   w.dof, w.f_re, w.f_im, w.nz, w.last,
                   got.dof, got.f_re, got.f_im, got.nz, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;

  force_board sb = new();
  int  cycles = 0;
  bit  quiet = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  n_random = 0;

  qtsh_force_adiabatic u_dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** qtsh_force_adiabatic: FAILED **");
      $finish;
    end
  end

  // receiver: long hold on request, otherwise random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 15);
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  // outputs are settled at the falling edge and hold until the next rising one
  always @(negedge clk_i) begin
    force_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.dof  = m_axis_tdata[3:0];
      got.f_re = m_axis_tdata[35:4];
      got.f_im = m_axis_tdata[67:36];
      got.nz   = m_axis_tuser[0];
      got.last = m_axis_tlast;
      sb.check_force(got);
    end
  end

  function automatic int rand_val();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return $urandom;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      3: return $urandom_range(0, 2) - 1;
      default: return $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
    endcase
  endfunction

  // starts and ends at a rising edge; valid stays up between back-to-back beats
  task automatic send(logic [2:0] kind, logic [3:0] dof, logic [2:0] row,
                      logic [2:0] col, int vr, int vi);
    bit took;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'b0, vi, vr, col, row, dof};
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      if (took) sb.note_request(kind, dof, row, col, vr, vi);
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic load(logic [2:0] kind, logic [3:0] dof, logic [2:0] row,
                      logic [2:0] col);
    send(kind, dof, row, col, rand_val(), rand_val());
  endtask

  task automatic compute();
    send(qtsh_pkg::CMD_COMPUTE, 4'($urandom), 3'($urandom), 3'($urandom),
         $urandom, $urandom);
  endtask

  // wait out every force, then the load queue behind it
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.forces_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(qtsh_pkg::cfg_idx_e idx, logic [4:0] v);
    bit took;
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    sb.set_reg(idx, v);
  endtask

  task automatic configure(bit m, logic [4:0] ns, logic [4:0] nd);
    drain();
    write_reg(qtsh_pkg::CFG_MODE, 5'(m));
    write_reg(qtsh_pkg::CFG_STATES, ns);
    write_reg(qtsh_pkg::CFG_DOFS, nd);
    cfg_valid_i <= 0;
  endtask

  task automatic zero_amps(int ns, int v);
    for (int i = 0; i < ns; i++) send(qtsh_pkg::CMD_LD_A, 4'd0, 3'(i), 3'd0, v, v);
  endtask

  initial begin
    int ns, len, pick;
    logic [4:0] st, df;
    bit md;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // every entry a compute can read gets a value before anything reads it
    for (int r = 0; r < NS_MAX; r++) begin
      send(qtsh_pkg::CMD_LD_A, 4'd0, 3'(r), 3'd0, rand_val(), rand_val());
      for (int c = 0; c < NS_MAX; c++) begin
        load(qtsh_pkg::CMD_LD_H, 4'd0, 3'(r), 3'(c));
        load(qtsh_pkg::CMD_LD_C, 4'd0, 3'(r), 3'(c));
        load(qtsh_pkg::CMD_LD_G, 4'd0, 3'(r), 3'(c));
        if (r < 4 && c < 4) begin
          load(qtsh_pkg::CMD_LD_C, 4'd1, 3'(r), 3'(c));
          load(qtsh_pkg::CMD_LD_G, 4'd1, 3'(r), 3'(c));
        end
      end
    end

    // directed: extremes, unused kinds, full state count in both modes
    send(qtsh_pkg::CMD_LD_H, 4'd0, 3'd7, 3'd7, 32'sh7FFFFFFF, 32'sh80000000);
    send(qtsh_pkg::CMD_LD_C, 4'd0, 3'd0, 3'd7, 32'sh80000000, 32'sh7FFFFFFF);
    send(qtsh_pkg::CMD_LD_G, 4'd0, 3'd7, 3'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send(qtsh_pkg::CMD_LD_A, 4'd0, 3'd7, 3'd0, 32'sh80000000, 32'sh80000000);
    for (int k = 1; k <= 3; k++)
      send(qtsh_pkg::CMD_COMPUTE + 3'(k), 4'hF, 3'h7, 3'h7, -1, -1);
    configure(0, 8, 1);
    compute();
    configure(1, 8, 1);
    compute();
    // clamped counts, single state
    configure(0, 0, 0);
    compute();
    configure(1, 0, 31);
    compute();
    configure(0, 15, 0);
    compute();
    // zero norm, plain and after rounding, then extreme amplitudes
    configure(0, 2, 2);
    zero_amps(2, 0);
    compute();
    zero_amps(2, 1);
    compute();
    send(qtsh_pkg::CMD_LD_A, 4'd0, 3'd0, 3'd0, 32'sh7FFFFFFF, 32'sh80000000);
    send(qtsh_pkg::CMD_LD_A, 4'd0, 3'd1, 3'd0, 32'sh80000000, 32'sh7FFFFFFF);
    compute();

    // random phases
    for (int ph = 0; n_random < N_RANDOM; ph++) begin
      md = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      st = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd8
         : (pick == 2) ? 5'($urandom_range(9, 15)) : 5'($urandom_range(2, 4));
      ns = (st < 1) ? 1 : (st > NS_MAX) ? NS_MAX : int'(st);
      pick = $urandom_range(0, 9);
      // more than one state only over the dofs that were filled
      if (ns == 1)
        df = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd31 : 5'($urandom_range(1, 16));
      else if (ns == NS_MAX)
        df = (pick == 0) ? 5'd0 : 5'd1;
      else
        df = (pick == 0) ? 5'd0 : 5'($urandom_range(1, 2));
      if (n_random > N_RANDOM - 20) quiet = 1;
      configure(md, st, df);
      if (ph == 2) begin
        // receiver holds off behind a compute while loads keep coming
        hold_left = 20000;
        compute();
        n_random++;
      end
      if ($urandom_range(0, 5) == 0) begin
        zero_amps(ns, $urandom_range(0, 1));
        compute();
        n_random += ns + 1;
      end
      len = $urandom_range(6, 14);
      for (int it = 0; it < len; it++) begin
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
          compute();
        end else if (pick == 3) begin
          send(qtsh_pkg::CMD_COMPUTE + 3'($urandom_range(1, 3)), 4'($urandom),
               3'($urandom), 3'($urandom), $urandom, $urandom);
        end else begin
          load(3'($urandom_range(0, 3)), 4'($urandom),
               ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, ns - 1)) : 3'($urandom),
               ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, ns - 1)) : 3'($urandom));
        end
        n_random++;
        // sender holds until every force due so far is out
        if (ph == 1 && it == len / 2) drain();
      end
      compute();
      n_random++;
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.forces_due.size() == 0) begin
      $display("** qtsh_force_adiabatic: PASSED **");
    end else begin
      $display("** qtsh_force_adiabatic: FAILED **");
    end
    $finish;
  end

endmodule

// ===== qtsh_force_adiabatic.f =====
rtl/qtsh_pkg.sv
rtl/qtsh_front.sv
rtl/qtsh_div.sv
rtl/qtsh_back.sv
rtl/qtsh_force_adiabatic.sv
tb/qtsh_force_adiabatic_test.sv
